// ===== sv/pcpd_pkg.sv =====
// package for the prefix code position decoder
// holds sizes, action and status codes and the cell hand-over type; no dependencies
package pcpd_pkg;
  localparam int unsigned MaxSymbols = 256;
  localparam int unsigned MaxDepth   = 50;
  localparam int unsigned IdxW       = $clog2(MaxSymbols);
  localparam int unsigned CntW       = $clog2(MaxSymbols + 1);
  localparam int unsigned CodeW      = MaxDepth;
  localparam int unsigned LenW       = 6;
  localparam int unsigned ValW       = 31;
  localparam int unsigned WinW       = 64;
  localparam int unsigned WbW        = 7;

  typedef enum logic [2:0] {
    ActLoad   = 3'd0,
    ActClear  = 3'd1,
    ActPush   = 3'd2,
    ActAlign  = 3'd3,
    ActDecode = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StNeedMore = 3'd1,
    StNoMatch  = 3'd2,
    StDictErr  = 3'd3,
    StWinFull  = 3'd4
  } status_e;

  // word handed from cell to cell along the match chain
  typedef struct packed {
    logic            found;
    logic            partial;
    logic [IdxW-1:0] idx;
    logic [ValW-1:0] value;
    logic [LenW-1:0] len;
  } match_t;
endpackage

// ===== sv/pcpd_if.sv =====
// valid/ready channel interfaces for the decoder
// depends on pcpd_pkg
interface pcpd_in_if (input logic clk_i);
  logic                      valid;
  logic                      ready;
  logic [2:0]                action;
  logic [5:0]                entry_depth;
  logic [pcpd_pkg::ValW-1:0] entry_value;
  logic [7:0]                data_byte;
  modport source (output valid, action, entry_depth, entry_value, data_byte, input ready);
  modport sink (input valid, action, entry_depth, entry_value, data_byte, output ready);
endinterface

interface pcpd_out_if (input logic clk_i);
  logic                      valid;
  logic                      ready;
  logic [2:0]                status;
  logic [pcpd_pkg::ValW-1:0] symbol_value;
  logic [7:0]                symbol_index;
  logic [5:0]                code_bits;
  modport source (output valid, status, symbol_value, symbol_index, code_bits, input ready);
  modport sink (input valid, status, symbol_value, symbol_index, code_bits, output ready);
endinterface

// ===== sv/pcpd_cell.sv =====
// one dictionary cell: holds an entry, compares it with the window, passes the match word on
// depends on pcpd_pkg
module pcpd_cell (
  input  logic                         clk_i,
  input  logic                         wr_i,
  input  logic [pcpd_pkg::CodeW-1:0]   code_i,
  input  logic [pcpd_pkg::LenW-1:0]    len_i,
  input  logic [pcpd_pkg::ValW-1:0]    value_i,
  input  logic                         live_i,
  input  logic [pcpd_pkg::IdxW-1:0]    my_idx_i,
  input  logic [pcpd_pkg::WinW-1:0]    win_i,
  input  logic [pcpd_pkg::WbW-1:0]     wbits_i,
  input  pcpd_pkg::match_t             m_i,
  output pcpd_pkg::match_t             m_o
);
  import pcpd_pkg::*;
  logic [CodeW-1:0] code_q;
  logic [LenW-1:0]  len_q;
  logic [ValW-1:0]  value_q;
  logic [CodeW-1:0] lmask, wmask;
  logic             full_hit, part_hit;

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      code_q  <= code_i;
      len_q   <= len_i;
      value_q <= value_i;
    end
  end

  always_comb begin
    for (int b = 0; b < CodeW; b++) begin
      lmask[b] = (b < int'(len_q));
      wmask[b] = (b < int'(wbits_i));
    end
    full_hit = live_i && ({1'b0, len_q} <= wbits_i)
               && ((win_i[CodeW-1:0] & lmask) == code_q);
    part_hit = live_i && ({1'b0, len_q} > wbits_i)
               && ((code_q & wmask) == (win_i[CodeW-1:0] & wmask));
    m_o = m_i;
    m_o.partial = m_i.partial | part_hit;
    if (full_hit && !m_i.found) begin
      m_o.found = 1'b1;
      m_o.idx   = my_idx_i;
      m_o.value = value_q;
      m_o.len   = len_q;
    end
  end
endmodule

// ===== sv/prefix_code_position_decoder.sv =====
// prefix code position decoder: top level with control, leaf builder and cell row
// depends on pcpd_pkg, pcpd_if, pcpd_cell
// latency: the result word is registered at the accepting edge and presented the cycle after
// throughput: one word per cycle while the result sink is ready; input stalls on an untaken result
// decode compares the window with all cells in one pass along the cell row
// reset clears count, leaf path and window; cell contents stay undefined until loaded
module prefix_code_position_decoder (
  input  logic clk_i,
  input  logic rst_ni,
  pcpd_in_if.sink    in_i,
  pcpd_out_if.source out_o
);
  import pcpd_pkg::*;

  logic [CntW-1:0]  count_q, count_d;
  logic [CodeW:0]   leaf_q, leaf_d;      // marker above depth bits, zero for none
  logic [WinW-1:0]  win_q, win_d;
  logic [WbW-1:0]   wbits_q, wbits_d;
  logic [2:0]       phase_q, phase_d;
  logic             ovalid_q;
  logic [2:0]       st_d;
  logic [ValW-1:0]  sv_d;
  logic [7:0]       si_d;
  logic [5:0]       cb_d;
  logic             acc, wr_en;

  assign in_i.ready = !ovalid_q || out_o.ready;
  assign acc        = in_i.valid && in_i.ready;
  assign out_o.valid = ovalid_q;

  // next leaf: find marker, step, scale to new depth; check that it fits, bit-reverse it for the cells
  logic [5:0]       last_len;
  logic [CodeW+1:0] nxt, cand;
  logic [CodeW-1:0] rev;
  logic             load_ok;
  logic [5:0]       dep;
  assign dep = in_i.entry_depth;

  always_comb begin
    last_len = '0;
    for (int b = 1; b <= CodeW; b++) if (leaf_q[b]) last_len = 6'(b);
    nxt = '0;
    for (int b = 0; b < CodeW; b++) if (b < int'(last_len)) nxt[b] = leaf_q[b];
    nxt = nxt + 1'b1;
    cand = '0;
    if (leaf_q != '0) begin
      if (dep >= last_len) cand = nxt << (dep - last_len);
      else cand = (nxt + ((CodeW+2)'(1) << (last_len - dep)) - 1'b1) >> (last_len - dep);
    end
    load_ok = (dep <= 6'(MaxDepth)) && (count_q < CntW'(MaxSymbols))
              && (cand < ((CodeW+2)'(1) << dep));
    rev = '0;
    for (int b = 0; b < CodeW; b++)
      if (b < int'(dep)) rev[b] = cand[int'(dep) - 1 - b];
  end

  assign wr_en = acc && (in_i.action == ActLoad) && load_ok;

  // cell row
  match_t chain [MaxSymbols+1];
  assign chain[0] = '0;
  for (genvar k = 0; k < MaxSymbols; k++) begin : g_cell
    pcpd_cell u_cell (
      .clk_i    (clk_i),
      .wr_i     (wr_en && (count_q[IdxW-1:0] == IdxW'(k))),
      .code_i   (rev),
      .len_i    (dep),
      .value_i  (in_i.entry_value),
      .live_i   (CntW'(k) < count_q),
      .my_idx_i (IdxW'(k)),
      .win_i    (win_q),
      .wbits_i  (wbits_q),
      .m_i      (chain[k]),
      .m_o      (chain[k+1])
    );
  end
  match_t res;
  assign res = chain[MaxSymbols];

  logic [2:0] drop;
  always_comb begin
    count_d = count_q; leaf_d = leaf_q; win_d = win_q;
    wbits_d = wbits_q; phase_d = phase_q;
    st_d = StOk; sv_d = '0; si_d = '0; cb_d = '0;
    drop = 3'(4'd8 - {1'b0, phase_q});
    if ({4'b0, drop} > wbits_q) drop = wbits_q[2:0];
    case (in_i.action)
      ActLoad: begin
        if (load_ok) begin
          count_d = count_q + 1'b1;
          leaf_d  = ((CodeW+1)'(1) << dep) | cand[CodeW:0];
        end else st_d = StDictErr;
      end
      ActClear: begin
        count_d = '0; leaf_d = '0; win_d = '0; wbits_d = '0; phase_d = '0;
      end
      ActPush: begin
        if (wbits_q > WbW'(WinW - 8)) st_d = StWinFull;
        else begin
          win_d   = win_q | (WinW'(in_i.data_byte) << wbits_q);
          wbits_d = wbits_q + WbW'(8);
        end
      end
      ActAlign: begin
        win_d   = win_q >> drop;
        wbits_d = wbits_q - WbW'(drop);
        phase_d = '0;
      end
      ActDecode: begin
        if (res.found) begin
          sv_d = res.value; si_d = 8'(res.idx); cb_d = res.len;
          win_d   = win_q >> res.len;
          wbits_d = wbits_q - WbW'(res.len);
          phase_d = phase_q + res.len[2:0];
        end else st_d = res.partial ? StNeedMore : StNoMatch;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0; leaf_q <= '0; win_q <= '0;
      wbits_q <= '0; phase_q <= '0; ovalid_q <= 1'b0;
    end else begin
      if (acc) begin
        count_q <= count_d; leaf_q <= leaf_d; win_q <= win_d;
        wbits_q <= wbits_d; phase_q <= phase_d;
        ovalid_q <= 1'b1;
      end else if (out_o.ready) ovalid_q <= 1'b0;
    end
  end

  // result word register
  always_ff @(posedge clk_i) begin
    if (acc) begin
      out_o.status       <= st_d;
      out_o.symbol_value <= sv_d;
      out_o.symbol_index <= si_d;
      out_o.code_bits    <= cb_d;
    end
  end
endmodule
